>>> hw/rtl/bitmap_first_fit_block_allocator_core_macros.svh
// Assertion macros for the block allocator.
// Included by modules that check their own logic; no other dependency.
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTH
`define BFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFA_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BFA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> hw/rtl/bfa_pkg.sv
// Package for the block allocator: sizes, status codes, state types.
// No dependencies.
package bfa_pkg;
    localparam int NumBlocks  = 512;
    localparam int BlockShift = 10;
    localparam int TableDepth = 64;
    localparam int BlkW   = $clog2(NumBlocks);
    localparam int CntW   = $clog2(NumBlocks + 1);
    localparam int EntW   = $clog2(TableDepth);
    localparam int EntCW  = $clog2(TableDepth + 1);
    localparam int SizeW  = 20;
    localparam int AddrW  = 32;
    localparam int QDepth = 2;

    localparam logic [1:0] REG_BASE = 2'd0;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_RUN     = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic             op;
        logic             bad;
        logic [CntW-1:0]  blocks;
        logic [AddrW-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic [AddrW-1:0] addr;
        logic [9:0]       blocks;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE, S_SLOT, S_SCAN, S_MARK, S_FIND, S_CLEAR, S_DONE
    } t_state;
endpackage

>>> hw/rtl/bitmap_first_fit_block_allocator_core.sv
// Block allocator top: APB base register, front queue, back engine.
// Allocate: slot search, then a bitmap scan (one bitmap bit a cycle), then the blocks are marked.
// Free: a table search (one entry a cycle), then the blocks are cleared.
// One item in the back engine at a time, so it takes no new command until the last is done;
// a two-entry command queue in front.
// Synchronous active-low reset: bitmap, table and queues empty, base 0.
module bitmap_first_fit_block_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [19:0] i_size_bytes,
    input  logic [31:0] i_release_address,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [31:0] o_granted_address,
    output logic [9:0]  o_granted_blocks
);
    logic [31:0]   r_base;
    logic          w_cmd_valid, w_take, w_res_valid;
    bfa_pkg::t_cmd w_cmd;
    bfa_pkg::t_res w_res;

    assign pready = 1'b1;
    assign prdata = (paddr == bfa_pkg::REG_BASE) ? r_base : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_base <= '0;
        else if (psel && penable && pwrite && paddr == bfa_pkg::REG_BASE) r_base <= pwdata;
    end

    bfa_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_op, .i_size_bytes,
        .i_release_address, .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_take)
    );

    bfa_back u_back (
        .i_clk, .i_rst_n, .i_base(r_base), .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_take(w_take), .o_res_valid(w_res_valid), .o_res(w_res),
        .i_res_pop(pop && !empty)
    );

    assign empty             = !w_res_valid;
    assign o_status          = w_res.status;
    assign o_granted_address = w_res.addr;
    assign o_granted_blocks  = w_res.blocks;
endmodule

>>> hw/rtl/bfa_front.sv
// Front end: rounds size to blocks, flags bad sizes, queues commands.
// Depends on bfa_pkg.
module bfa_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_op,
    input  logic [19:0]           i_size_bytes,
    input  logic [31:0]           i_release_address,
    output logic                  o_cmd_valid,
    output bfa_pkg::t_cmd         o_cmd,
    input  logic                  i_cmd_take
);
    localparam int PW = $clog2(bfa_pkg::QDepth);
    bfa_pkg::t_cmd r_q [bfa_pkg::QDepth];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    bfa_pkg::t_cmd w_cmd;
    logic [bfa_pkg::SizeW-bfa_pkg::BlockShift:0] w_blk;
    logic w_push, w_pop;

    always_comb begin
        w_blk = {1'b0, i_size_bytes[bfa_pkg::SizeW-1:bfa_pkg::BlockShift]}
              + {{(bfa_pkg::SizeW-bfa_pkg::BlockShift){1'b0}},
                 |i_size_bytes[bfa_pkg::BlockShift-1:0]};
        w_cmd.op     = i_op;
        w_cmd.bad    = (w_blk == '0) ||
                       (w_blk > (bfa_pkg::SizeW-bfa_pkg::BlockShift+1)'(bfa_pkg::NumBlocks));
        w_cmd.blocks = w_blk[bfa_pkg::CntW-1:0];
        w_cmd.addr   = i_release_address;
    end

    assign o_full      = (r_cnt == (PW+1)'(bfa_pkg::QDepth));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end
endmodule

>>> hw/rtl/bfa_back.sv
// Back end: bitmap scan, table search, bitmap update, result register.
// Depends on bfa_pkg and the assertion macro header.
`include "bitmap_first_fit_block_allocator_core_macros.svh"
module bfa_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_base,
    input  logic          i_cmd_valid,
    input  bfa_pkg::t_cmd i_cmd,
    output logic          o_cmd_take,
    output logic          o_res_valid,
    output bfa_pkg::t_res o_res,
    input  logic          i_res_pop
);
    localparam int BW = bfa_pkg::BlkW;
    localparam int CW = bfa_pkg::CntW;
    localparam int EW = bfa_pkg::EntW;

    bfa_pkg::t_state r_state, n_state;
    logic [bfa_pkg::NumBlocks-1:0]  r_used;
    logic [bfa_pkg::TableDepth-1:0] r_valid;
    logic [BW-1:0] r_start_mem [bfa_pkg::TableDepth];
    logic [CW-1:0] r_cnt_mem   [bfa_pkg::TableDepth];
    bfa_pkg::t_cmd r_cmd;
    logic [BW:0]   r_idx;
    logic [CW-1:0] r_run;
    logic [BW-1:0] r_start;
    logic [EW-1:0] r_slot;
    logic [EW:0]   r_eidx;
    logic [CW-1:0] r_left;
    logic [BW-1:0] r_pos;
    logic          r_res_v;
    bfa_pkg::t_res r_res;
    bfa_pkg::t_res r_wres;
    logic [BW-1:0] r_rd_start;
    logic [CW-1:0] r_rd_cnt;
    logic          r_rd_hit;

    logic          w_load, w_res_free, w_hit_slot;
    logic [EW-1:0] w_free_slot;
    logic [31:0]   w_eaddr;

    assign w_res_free = !r_res_v || i_res_pop;
    assign o_cmd_take = (r_state == bfa_pkg::S_IDLE) && i_cmd_valid;
    assign w_load     = o_cmd_take;
    assign o_res_valid = r_res_v;
    assign o_res       = r_res;

    always_comb begin
        w_hit_slot  = 1'b0;
        w_free_slot = '0;
        for (int e = bfa_pkg::TableDepth-1; e >= 0; e--) begin
            if (!r_valid[e]) begin
                w_hit_slot  = 1'b1;
                w_free_slot = EW'(e);
            end
        end
    end

    assign w_eaddr = i_base + (32'(r_rd_start) << bfa_pkg::BlockShift);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfa_pkg::S_IDLE: if (i_cmd_valid) begin
                if (i_cmd.op == bfa_pkg::OP_FREE) n_state = bfa_pkg::S_FIND;
                else if (i_cmd.bad) n_state = bfa_pkg::S_DONE;
                else n_state = bfa_pkg::S_SLOT;
            end
            bfa_pkg::S_SLOT: n_state = w_hit_slot ? bfa_pkg::S_SCAN : bfa_pkg::S_DONE;
            bfa_pkg::S_SCAN: begin
                if (!r_used[r_idx[BW-1:0]] && (r_run + 1'b1 == r_cmd.blocks))
                    n_state = bfa_pkg::S_MARK;
                else if (r_idx == (BW+1)'(bfa_pkg::NumBlocks-1))
                    n_state = bfa_pkg::S_DONE;
            end
            bfa_pkg::S_MARK:  if (r_left == CW'(1)) n_state = bfa_pkg::S_DONE;
            bfa_pkg::S_FIND: begin
                if (r_rd_hit && w_eaddr == r_cmd.addr) n_state = bfa_pkg::S_CLEAR;
                else if (r_eidx == (EW+1)'(bfa_pkg::TableDepth)) n_state = bfa_pkg::S_DONE;
            end
            bfa_pkg::S_CLEAR: if (r_left == CW'(1)) n_state = bfa_pkg::S_DONE;
            bfa_pkg::S_DONE:  if (w_res_free) n_state = bfa_pkg::S_IDLE;
            default: n_state = bfa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= bfa_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // table read port, one entry a cycle
    always_ff @(posedge i_clk) begin
        r_rd_start <= r_start_mem[r_eidx[EW-1:0]];
        r_rd_cnt   <= r_cnt_mem[r_eidx[EW-1:0]];
        if (r_state == bfa_pkg::S_MARK && r_left == CW'(1)) begin
            r_start_mem[r_slot] <= r_start;
            r_cnt_mem[r_slot]   <= r_cmd.blocks;
        end
    end

    // r_wres is built while the item runs; r_res holds the waiting result
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_cmd;
            r_idx <= '0;
            r_run <= '0;
            r_eidx <= '0;
            r_wres <= '{status: bfa_pkg::ST_NO_RUN, addr: '0, blocks: '0};
        end
        if (r_state == bfa_pkg::S_DONE && w_res_free) r_res <= r_wres;
        unique case (r_state)
            bfa_pkg::S_SLOT: begin
                r_slot <= w_free_slot;
                if (!w_hit_slot) r_wres.status <= bfa_pkg::ST_TABLE_FULL;
            end
            bfa_pkg::S_SCAN: begin
                r_idx <= r_idx + 1'b1;
                if (r_used[r_idx[BW-1:0]]) r_run <= '0;
                else r_run <= r_run + 1'b1;
                if (!r_used[r_idx[BW-1:0]] && (r_run + 1'b1 == r_cmd.blocks)) begin
                    r_start <= BW'(r_idx + (BW+1)'(1) - (BW+1)'(r_cmd.blocks));
                    r_pos   <= BW'(r_idx + (BW+1)'(1) - (BW+1)'(r_cmd.blocks));
                    r_left  <= r_cmd.blocks;
                    r_wres  <= '{status: bfa_pkg::ST_OK,
                                 addr: i_base + (32'(BW'(r_idx + (BW+1)'(1)
                                       - (BW+1)'(r_cmd.blocks))) << bfa_pkg::BlockShift),
                                 blocks: 10'(r_cmd.blocks)};
                end
            end
            bfa_pkg::S_MARK, bfa_pkg::S_CLEAR: begin
                r_pos  <= r_pos + 1'b1;
                r_left <= r_left - 1'b1;
            end
            bfa_pkg::S_FIND: begin
                r_eidx <= r_eidx + 1'b1;
                if (r_rd_hit && w_eaddr == r_cmd.addr) begin
                    r_pos  <= r_rd_start;
                    r_left <= r_rd_cnt;
                    r_slot <= EW'(r_eidx - 1'b1);
                    r_wres <= '{status: bfa_pkg::ST_OK, addr: '0, blocks: 10'(r_rd_cnt)};
                end else if (r_eidx == (EW+1)'(bfa_pkg::TableDepth)) begin
                    r_wres.status <= bfa_pkg::ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_valid  <= '0;
            r_res_v  <= 1'b0;
            r_rd_hit <= 1'b0;
        end else begin
            r_rd_hit <= (r_state == bfa_pkg::S_FIND || w_load) &&
                        (r_eidx < (EW+1)'(bfa_pkg::TableDepth)) && !w_load &&
                        r_valid[r_eidx[EW-1:0]];
            if (r_state == bfa_pkg::S_MARK) begin
                r_used[r_pos] <= 1'b1;
                if (r_left == CW'(1)) r_valid[r_slot] <= 1'b1;
            end
            if (r_state == bfa_pkg::S_FIND && r_rd_hit && w_eaddr == r_cmd.addr)
                r_valid[EW'(r_eidx - 1'b1)] <= 1'b0;
            if (r_state == bfa_pkg::S_CLEAR && r_left != '0)
                r_used[r_pos] <= 1'b0;
            if (r_state == bfa_pkg::S_DONE && w_res_free) r_res_v <= 1'b1;
            else if (i_res_pop) r_res_v <= 1'b0;
        end
    end

    `BFA_ASSERT(a_take_idle, i_clk, i_rst_n,
        o_cmd_take |-> r_state == bfa_pkg::S_IDLE, "take outside idle")
    `BFA_ASSERT(a_ok_blocks, i_clk, i_rst_n,
        (r_res_v && r_res.status == bfa_pkg::ST_OK) |-> r_res.blocks != '0,
        "ok result with no blocks")
    `BFA_ASSERT(a_fail_zero, i_clk, i_rst_n,
        (r_res_v && r_res.status != bfa_pkg::ST_OK) |-> (r_res.blocks == '0 && r_res.addr == '0),
        "failure result not zeroed")
endmodule
